// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/cau_pkg.sv =====
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS_DEF = 12;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_MAG = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]                   mode;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         overflow;
        logic                         divide_by_zero;
    } t_out_req;

endpackage
`default_nettype wire

// ===== hdl/cau_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage: quo = floor(num * 2^F / den).
// o_ovf marks a quotient of 2^W or more.
module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic                              i_neg,
    input  wire logic [2*cau_pkg::DATA_WIDTH-1:0]  i_num,
    input  wire logic [2*cau_pkg::DATA_WIDTH-1:0]  i_den,
    output logic                                   o_neg,
    output logic [cau_pkg::DATA_WIDTH-1:0]         o_quo,
    output logic                                   o_ovf
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int CW = 3 * W + FRAC_BITS;

    logic [CW-1:0] r_rem [W-1];
    logic [CW-1:0] r_den [W-1];
    logic [W-1:0]  r_quo [W];
    logic          r_neg [W];
    logic          r_ovf [W];

    for (genvar s = 0; s < W; s++) begin : g_st
        logic [CW-1:0] rem_in;
        logic [CW-1:0] den_in;
        logic [CW-1:0] trial;
        logic [W-1:0]  quo_in;
        logic          neg_in;
        logic          ovf_in;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in = CW'(i_num) << FRAC_BITS;
            assign den_in = CW'(i_den);
            assign quo_in = '0;
            assign neg_in = i_neg;
            assign ovf_in = rem_in >= (den_in << W);
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
            assign neg_in = r_neg[s-1];
            assign ovf_in = r_ovf[s-1];
        end

        assign trial = den_in << (W - 1 - s);
        assign take  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= take ? (quo_in | (W'(1) << (W - 1 - s))) : quo_in;
                r_neg[s] <= neg_in;
                r_ovf[s] <= ovf_in;
            end
        end

        if (s < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? (rem_in - trial) : rem_in;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_neg = r_neg[W-1];
    assign o_quo = r_quo[W-1];
    assign o_ovf = r_ovf[W-1];

endmodule
`default_nettype wire

// ===== hdl/cau_sqrt.sv =====
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module cau_sqrt (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [2*cau_pkg::DATA_WIDTH-1:0] i_n,
    output logic [cau_pkg::DATA_WIDTH-1:0]        o_root
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int RW = 2 * W + 1;

    logic [RW-1:0] r_rem  [W-1];
    logic [W-1:0]  r_root [W];

    for (genvar s = 0; s < W; s++) begin : g_st
        localparam int I = W - 1 - s;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] term;
        logic [W-1:0]  root_in;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in  = RW'(i_n);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // (r + 2^i)^2 - r^2
        assign term = (RW'(root_in) << (I + 1)) + (RW'(1) << (2 * I));
        assign take = rem_in >= term;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= take ? (root_in | (W'(1) << I)) : root_in;
            end
        end

        if (s < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? (rem_in - term) : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[W-1];

endmodule
`default_nettype wire

// ===== hdl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Request in: i_in_valid / o_in_stall with i_in_req (mode, a, b). Request
// out: o_out_valid / i_out_stall with o_out_req (result, overflow and
// divide-by-zero flags). A request moves when valid is high and stall low.
// Modes: add, subtract, multiply, divide, magnitude of a (in res_re).
// The pipeline has one multiply stage,
// one sum stage, DATA_WIDTH divider / square-root stages (one quotient or
// root bit each), one saturation and output stage.
// Throughput is one request per cycle while the receiver does not stall; every
// mode takes the same path length, so results leave in request order.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears the valid bits of every stage; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cau_pkg::t_in_req i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output cau_pkg::t_out_req     o_out_req
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] Q_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] Q_LO = {1'b1, {(W-1){1'b0}}};

    logic en;

    // stage A: products
    logic                 r_va;
    logic [2:0]           r_a_mode;
    logic signed [W-1:0]  r_a_ar, r_a_ai, r_a_br, r_a_bi;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_xx, r_p_yy;
    logic signed [W-1:0]  sq_x, sq_y;

    // stage B: sums
    logic                 r_vb;
    logic [2:0]           r_b_mode;
    logic signed [SW-1:0] r_b_re, r_b_im;
    logic [PW-1:0]        r_b_den;
    logic signed [SW-1:0] n_b_re, n_b_im;
    logic [PW-1:0]        n_b_den;

    // side path beside the divider and square root
    logic                r_dv   [W];
    logic [2:0]          r_dmode[W];
    logic [W-1:0]        r_dre  [W];
    logic [W-1:0]        r_dim  [W];
    logic                r_dovf [W];
    logic                r_ddz  [W];
    logic [W:0]          sat_re, sat_im;
    logic [W-1:0]        n_dre, n_dim;
    logic                n_dovf;

    logic                div_re_neg, div_im_neg, div_re_ovf, div_im_ovf;
    logic [W-1:0]        div_re_q, div_im_q, root;
    logic [PW-1:0]       num_re_mag, num_im_mag;
    logic [W:0]          q_re, q_im;

    logic                r_out_valid;
    cau_pkg::t_out_req   r_out_req, n_out_req;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] v);
        if (v > SAT_HI) begin
            sat_wide = {1'b1, SAT_HI[W-1:0]};
        end else if (v < SAT_LO) begin
            sat_wide = {1'b1, SAT_LO[W-1:0]};
        end else begin
            sat_wide = {1'b0, v[W-1:0]};
        end
    endfunction

    // sign-magnitude quotient to saturated two's complement, {ovf, value}
    function automatic logic [W:0] sat_quo(input logic neg, input logic [W-1:0] q,
                                           input logic ovf);
        if (neg) begin
            if (ovf || q > Q_LO) begin
                sat_quo = {1'b1, Q_LO};
            end else begin
                sat_quo = {1'b0, W'(-q)};
            end
        end else begin
            if (ovf || q > Q_HI) begin
                sat_quo = {1'b1, Q_HI};
            end else begin
                sat_quo = {1'b0, q};
            end
        end
    endfunction

    // magnitude mode squares a through the divisor multipliers
    assign sq_x = (cau_pkg::t_mode'(i_in_req.mode) == cau_pkg::MODE_MAG) ?
                  i_in_req.a_re : i_in_req.b_re;
    assign sq_y = (cau_pkg::t_mode'(i_in_req.mode) == cau_pkg::MODE_MAG) ?
                  i_in_req.a_im : i_in_req.b_im;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode <= i_in_req.mode;
            r_a_ar   <= i_in_req.a_re;
            r_a_ai   <= i_in_req.a_im;
            r_a_br   <= i_in_req.b_re;
            r_a_bi   <= i_in_req.b_im;
            r_p_rr   <= PW'(i_in_req.a_re) * PW'(i_in_req.b_re);
            r_p_ii   <= PW'(i_in_req.a_im) * PW'(i_in_req.b_im);
            r_p_ri   <= PW'(i_in_req.a_re) * PW'(i_in_req.b_im);
            r_p_ir   <= PW'(i_in_req.a_im) * PW'(i_in_req.b_re);
            r_p_xx   <= PW'(sq_x) * PW'(sq_x);
            r_p_yy   <= PW'(sq_y) * PW'(sq_y);
        end
    end

    always_comb begin
        n_b_den = PW'(r_p_xx) + PW'(r_p_yy);
        unique case (cau_pkg::t_mode'(r_a_mode))
            cau_pkg::MODE_ADD: begin
                n_b_re = SW'(r_a_ar) + SW'(r_a_br);
                n_b_im = SW'(r_a_ai) + SW'(r_a_bi);
            end
            cau_pkg::MODE_SUB: begin
                n_b_re = SW'(r_a_ar) - SW'(r_a_br);
                n_b_im = SW'(r_a_ai) - SW'(r_a_bi);
            end
            cau_pkg::MODE_MUL: begin
                n_b_re = (SW'(r_p_rr) - SW'(r_p_ii)) >>> FRAC_BITS;
                n_b_im = (SW'(r_p_ri) + SW'(r_p_ir)) >>> FRAC_BITS;
            end
            cau_pkg::MODE_DIV: begin
                n_b_re = SW'(r_p_rr) + SW'(r_p_ii);
                n_b_im = SW'(r_p_ir) - SW'(r_p_ri);
            end
            default: begin
                n_b_re = '0;
                n_b_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mode <= r_a_mode;
            r_b_re   <= n_b_re;
            r_b_im   <= n_b_im;
            r_b_den  <= n_b_den;
        end
    end

    assign num_re_mag = r_b_re[SW-1] ? PW'(-r_b_re) : PW'(r_b_re);
    assign num_im_mag = r_b_im[SW-1] ? PW'(-r_b_im) : PW'(r_b_im);

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (r_b_re[SW-1]),
        .i_num (num_re_mag),
        .i_den (r_b_den),
        .o_neg (div_re_neg),
        .o_quo (div_re_q),
        .o_ovf (div_re_ovf)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (r_b_im[SW-1]),
        .i_num (num_im_mag),
        .i_den (r_b_den),
        .o_neg (div_im_neg),
        .o_quo (div_im_q),
        .o_ovf (div_im_ovf)
    );

    cau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    (r_b_den),
        .o_root (root)
    );

    assign sat_re = sat_wide(r_b_re);
    assign sat_im = sat_wide(r_b_im);

    always_comb begin
        unique case (cau_pkg::t_mode'(r_b_mode))
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
                n_dre  = sat_re[W-1:0];
                n_dim  = sat_im[W-1:0];
                n_dovf = sat_re[W] | sat_im[W];
            end
            default: begin
                n_dre  = '0;
                n_dim  = '0;
                n_dovf = 1'b0;
            end
        endcase
    end

    for (genvar s = 0; s < W; s++) begin : g_side
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dmode[s] <= r_b_mode;
                    r_dre[s]   <= n_dre;
                    r_dim[s]   <= n_dim;
                    r_dovf[s]  <= n_dovf;
                    r_ddz[s]   <= (r_b_den == '0);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dmode[s] <= r_dmode[s-1];
                    r_dre[s]   <= r_dre[s-1];
                    r_dim[s]   <= r_dim[s-1];
                    r_dovf[s]  <= r_dovf[s-1];
                    r_ddz[s]   <= r_ddz[s-1];
                end
            end
        end
    end

    assign q_re = sat_quo(div_re_neg, div_re_q, div_re_ovf);
    assign q_im = sat_quo(div_im_neg, div_im_q, div_im_ovf);

    always_comb begin
        n_out_req = '0;
        unique case (cau_pkg::t_mode'(r_dmode[W-1]))
            cau_pkg::MODE_DIV: begin
                if (r_ddz[W-1]) begin
                    n_out_req.divide_by_zero = 1'b1;
                end else begin
                    n_out_req.res_re   = q_re[W-1:0];
                    n_out_req.res_im   = q_im[W-1:0];
                    n_out_req.overflow = q_re[W] | q_im[W];
                end
            end
            cau_pkg::MODE_MAG: begin
                n_out_req.res_re   = root[W-1] ? Q_HI : root;
                n_out_req.overflow = root[W-1];
            end
            default: begin
                n_out_req.res_re   = r_dre[W-1];
                n_out_req.res_im   = r_dim[W-1];
                n_out_req.overflow = r_dovf[W-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_req <= n_out_req;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_va        <= i_in_valid;
            r_vb        <= r_va;
            r_out_valid <= r_dv[W-1];
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_valid
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[s] <= 1'b0;
                end else if (en) begin
                    r_dv[s] <= r_vb;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[s] <= 1'b0;
                end else if (en) begin
                    r_dv[s] <= r_dv[s-1];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    `CAU_ASSERT(a_flags_excl, i_clk, i_rst_n,
        o_out_valid |-> !(o_out_req.overflow && o_out_req.divide_by_zero),
        "overflow and divide_by_zero both set")
    `CAU_ASSERT(a_dz_zero, i_clk, i_rst_n,
        (o_out_valid && o_out_req.divide_by_zero) |->
            (o_out_req.res_re == '0 && o_out_req.res_im == '0),
        "divide by zero with nonzero result")
    `CAU_ASSERT(a_backpressure, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |-> o_in_stall,
        "input taken while output is blocked")

endmodule
`default_nettype wire
